@@ design/hbm_pkg.sv @@
// hash bit error rate matcher: shared field widths, codes and control types
// used by the controller, the datapath and the top level; no dependencies
package hbm_pkg;

   // field widths
   localparam int FUNC_W     = 2;
   localparam int WORD_W     = 32;
   localparam int OFF_W      = 10;
   localparam int BW_W       = 11;
   localparam int THR_W      = 17;
   localparam int SCORE_W    = 17;
   localparam int VO_W       = 11;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // block math widths
   localparam int D_W       = 16;
   localparam int E_W       = 16;
   localparam int POP_W     = 6;
   localparam int PROD_W    = 33;
   localparam int QUO_BITS  = 17;
   localparam int DIV_CNT_W = 5;

   // register reset values
   localparam logic [BW_W-1:0]  BW_RESET  = 11'd256;
   localparam logic [THR_W-1:0] THR_RESET = 17'd19661;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_APPEND1 = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_APPEND2 = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_SCORE   = 2'd3;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SHORT = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_WORDS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD   = 2'd1;

   // controller to datapath commands
   typedef struct packed {
      logic latch;
      logic exec;
      logic scan;
      logic div_init;
      logic div_step;
   } hbm_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic go_scan;
      logic issue_last;
      logic pipe_busy;
      logic div_last;
   } hbm_sts_type;

endpackage

@@ design/hbm_ram.sv @@
// generic single write port, single read port ram with registered read data
// no dependencies
module hbm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/hbm_datapath.sv @@
// hash bit error rate matcher datapath: hash stores, counts, config registers,
// block error pipeline, score accumulators and the serial divider
// depends on hbm_pkg and hbm_ram
module hbm_datapath #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  hbm_pkg::hbm_cmd_type                 cmd,
   output hbm_pkg::hbm_sts_type                 sts,
   input  logic [hbm_pkg::FUNC_W-1:0]           req_func,
   input  logic [hbm_pkg::WORD_W-1:0]           req_hash_word,
   input  logic [hbm_pkg::OFF_W-1:0]            req_offset,
   input  logic                                 csr_wr,
   input  logic [hbm_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [hbm_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic [hbm_pkg::SCORE_W-1:0]          score_q16,
   output logic [hbm_pkg::VO_W-1:0]             valid_offsets,
   output logic [hbm_pkg::STATUS_W-1:0]         status
);

   localparam int FUNC_W    = hbm_pkg::FUNC_W;
   localparam int WORD_W    = hbm_pkg::WORD_W;
   localparam int OFF_W     = hbm_pkg::OFF_W;
   localparam int BW_W      = hbm_pkg::BW_W;
   localparam int THR_W     = hbm_pkg::THR_W;
   localparam int SCORE_W   = hbm_pkg::SCORE_W;
   localparam int VO_W      = hbm_pkg::VO_W;
   localparam int STATUS_W  = hbm_pkg::STATUS_W;
   localparam int D_W       = hbm_pkg::D_W;
   localparam int E_W       = hbm_pkg::E_W;
   localparam int POP_W     = hbm_pkg::POP_W;
   localparam int PROD_W    = hbm_pkg::PROD_W;
   localparam int DIV_CNT_W = hbm_pkg::DIV_CNT_W;

   localparam int AW     = $clog2(STORE_DEPTH);
   localparam int CW     = $clog2(STORE_DEPTH + 1);
   localparam int NC_W   = $clog2(STORE_DEPTH + 2);
   localparam int CMP_W  = (NC_W > OFF_W) ? NC_W : OFF_W;
   localparam int CB_W   = (CW > BW_W) ? CW : BW_W;
   localparam int MD_W   = $clog2(32 * STORE_DEPTH + 1);
   localparam int T_W    = MD_W + 1;

   // 32-bit popcount as nibble counts summed one after another
   function automatic logic [POP_W-1:0] pop32(input logic [WORD_W-1:0] v);
      logic [POP_W-1:0] total;
      logic [2:0]       nib;
      total = '0;
      for (int n = 0; n < WORD_W / 4; n++) begin
         nib = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
         total = total + POP_W'(nib);
      end
      return total;
   endfunction

   // latched transaction
   logic [FUNC_W-1:0] func_ff;
   logic [WORD_W-1:0] word_ff;
   logic [OFF_W-1:0]  offset_ff;

   // configuration registers
   logic [BW_W-1:0]  bw_cfg_ff;
   logic [THR_W-1:0] thr_cfg_ff;

   // store fill counts
   logic [CW-1:0] cnt1_ff;
   logic [CW-1:0] cnt2_ff;

   // walk state
   logic          first_short_ff;
   logic [CW-1:0] ia_ff;
   logic [CW-1:0] ib_ff;
   logic [CW-1:0] rem_ff;
   logic [BW_W-1:0] j_ff;

   // error pipeline
   logic             s1_valid_ff;
   logic             s1_last_ff;
   logic             s2_valid_ff;
   logic             s2_last_ff;
   logic [POP_W-1:0] pop_ff;
   logic [E_W-1:0]   e_ff;
   logic [E_W-1:0]   e_blk_ff;
   logic             s3_valid_ff;

   // block compare and accumulators
   logic [PROD_W-1:0] thr_d_ff;
   logic [D_W-1:0]    d_ff;
   logic [T_W-1:0]    t_ff;
   logic [MD_W-1:0]   md_ff;

   // divider
   logic [MD_W-1:0]      rem_div_ff;
   logic [SCORE_W-1:0]   low_ff;
   logic [DIV_CNT_W-1:0] div_cnt_ff;

   // result registers
   logic [SCORE_W-1:0]  score_ff;
   logic [VO_W-1:0]     vo_ff;
   logic [STATUS_W-1:0] status_ff;

   // ram ports
   logic [WORD_W-1:0] rd1_data;
   logic [WORD_W-1:0] rd2_data;
   logic [AW-1:0]     rd1_addr;
   logic [AW-1:0]     rd2_addr;
   logic              wr1_en;
   logic              wr2_en;

   // decode of the latched request
   logic [BW_W-1:0] bw;
   logic            first_short;
   logic [CW-1:0]   n1;
   logic [CW-1:0]   n2;
   logic [NC_W-1:0] nc;
   logic            too_short;
   logic            out_range;
   logic            full1;
   logic            full2;
   logic [D_W-1:0]  d_in;
   logic [PROD_W-1:0] thr_d_in;

   // walk and pipeline next values
   logic             last_word;
   logic             end_scan;
   logic [POP_W-1:0] pop_in;
   logic [E_W-1:0]   e_in;
   logic             below;
   logic [T_W-1:0]   t_in;
   logic [MD_W:0]    r2;
   logic             q_bit;
   logic [MD_W-1:0]  rem_div_in;

   assign bw          = (bw_cfg_ff == '0) ? BW_W'(1) : bw_cfg_ff;
   assign first_short = cnt1_ff <= cnt2_ff;
   assign n1          = first_short ? cnt1_ff : cnt2_ff;
   assign n2          = first_short ? cnt2_ff : cnt1_ff;
   assign nc          = NC_W'(n2 - n1) + NC_W'(1);
   assign too_short   = CB_W'(n1) < CB_W'(bw);
   assign out_range   = CMP_W'(offset_ff) >= CMP_W'(nc);
   assign full1       = cnt1_ff == CW'(STORE_DEPTH);
   assign full2       = cnt2_ff == CW'(STORE_DEPTH);
   assign d_in        = {bw, 5'b0};
   assign thr_d_in    = PROD_W'(thr_cfg_ff) * PROD_W'(d_in);

   // store writes on append to a store that is not full
   assign wr1_en = cmd.exec && (func_ff == hbm_pkg::FUNC_APPEND1) && !full1;
   assign wr2_en = cmd.exec && (func_ff == hbm_pkg::FUNC_APPEND2) && !full2;

   // shorter store walks from zero, longer store from the offset
   assign rd1_addr = first_short_ff ? ia_ff[AW-1:0] : ib_ff[AW-1:0];
   assign rd2_addr = first_short_ff ? ib_ff[AW-1:0] : ia_ff[AW-1:0];

   assign last_word = j_ff == (bw - BW_W'(1));
   assign end_scan  = last_word && (CB_W'(rem_ff) <= CB_W'(bw));
   assign pop_in    = pop32(rd1_data ^ rd2_data);
   assign e_in      = e_ff + E_W'(pop_ff);

   // block is below threshold when e*65536 <= threshold*d
   assign below = PROD_W'({e_blk_ff, 16'h0}) <= thr_d_ff;
   assign t_in  = below ? (T_W'({d_ff, 1'b0}) - T_W'(e_blk_ff)) : T_W'(e_blk_ff);

   // restoring division step
   assign r2         = {rem_div_ff, low_ff[SCORE_W-1]};
   assign q_bit      = r2 >= {1'b0, md_ff};
   assign rem_div_in = q_bit ? MD_W'(r2 - {1'b0, md_ff}) : MD_W'(r2);

   hbm_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_first_ram (
      .clock   (clock),
      .wr_en   (wr1_en),
      .wr_addr (cnt1_ff[AW-1:0]),
      .wr_data (word_ff),
      .rd_addr (rd1_addr),
      .rd_data (rd1_data)
   );

   hbm_ram #(.WIDTH(WORD_W), .DEPTH(STORE_DEPTH)) u_second_ram (
      .clock   (clock),
      .wr_en   (wr2_en),
      .wr_addr (cnt2_ff[AW-1:0]),
      .wr_data (word_ff),
      .rd_addr (rd2_addr),
      .rd_data (rd2_data)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         bw_cfg_ff  <= hbm_pkg::BW_RESET;
         thr_cfg_ff <= hbm_pkg::THR_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            hbm_pkg::CSR_BLOCK_WORDS: bw_cfg_ff  <= csr_wdata[BW_W-1:0];
            hbm_pkg::CSR_THRESHOLD:   thr_cfg_ff <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         func_ff   <= req_func;
         word_ff   <= req_hash_word;
         offset_ff <= req_offset;
      end
   end

   // store counts
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt1_ff <= '0;
         cnt2_ff <= '0;
      end else if (cmd.exec) begin
         if (func_ff == hbm_pkg::FUNC_CLEAR) begin
            cnt1_ff <= '0;
            cnt2_ff <= '0;
         end
         if (wr1_en) begin
            cnt1_ff <= cnt1_ff + CW'(1);
         end
         if (wr2_en) begin
            cnt2_ff <= cnt2_ff + CW'(1);
         end
      end
   end

   // result fields, walk setup and advance, and quotient shift
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         score_ff  <= '0;
         vo_ff     <= '0;
         status_ff <= hbm_pkg::STATUS_OK;
         case (func_ff)
            hbm_pkg::FUNC_APPEND1: begin
               if (full1) begin
                  status_ff <= hbm_pkg::STATUS_FULL;
               end
            end
            hbm_pkg::FUNC_APPEND2: begin
               if (full2) begin
                  status_ff <= hbm_pkg::STATUS_FULL;
               end
            end
            hbm_pkg::FUNC_SCORE: begin
               if (too_short) begin
                  status_ff <= hbm_pkg::STATUS_SHORT;
               end else begin
                  vo_ff <= VO_W'(nc);
                  if (out_range) begin
                     status_ff <= hbm_pkg::STATUS_RANGE;
                  end
               end
            end
            default: ;
         endcase
         first_short_ff <= first_short;
         ia_ff          <= '0;
         ib_ff          <= CW'(offset_ff);
         rem_ff         <= n1;
         j_ff           <= '0;
         d_ff           <= d_in;
         thr_d_ff       <= thr_d_in;
      end else if (cmd.scan) begin
         ia_ff  <= ia_ff + CW'(1);
         ib_ff  <= ib_ff + CW'(1);
         rem_ff <= rem_ff - CW'(1);
         j_ff   <= last_word ? '0 : j_ff + BW_W'(1);
      end else if (cmd.div_step) begin
         score_ff <= {score_ff[SCORE_W-2:0], q_bit};
      end
   end

   // error pipeline valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.scan;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff && s2_last_ff;
      end
   end

   // error pipeline payload: popcount, block error sum
   always_ff @(posedge clock) begin
      s1_last_ff <= last_word;
      s2_last_ff <= s1_last_ff;
      pop_ff     <= pop_in;
      if (cmd.exec) begin
         e_ff <= '0;
      end else if (s2_valid_ff) begin
         if (s2_last_ff) begin
            e_blk_ff <= e_in;
            e_ff     <= '0;
         end else begin
            e_ff <= e_in;
         end
      end
   end

   // score accumulators: t = m*d + s, md = m*d
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         t_ff  <= '0;
         md_ff <= '0;
      end else if (s3_valid_ff) begin
         t_ff  <= t_ff + t_in;
         md_ff <= md_ff + MD_W'(d_ff);
      end
   end

   // serial divider, one quotient bit per cycle
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_div_ff <= MD_W'(t_ff >> 2);
         low_ff     <= {t_ff[1:0], 15'h0};
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_div_ff <= rem_div_in;
         low_ff     <= {low_ff[SCORE_W-2:0], 1'b0};
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
   end

   // status to the controller
   always_comb begin
      sts.go_scan    = (func_ff == hbm_pkg::FUNC_SCORE) && !too_short && !out_range;
      sts.issue_last = cmd.scan && end_scan;
      sts.pipe_busy  = s1_valid_ff || s2_valid_ff || s3_valid_ff;
      sts.div_last   = div_cnt_ff == DIV_CNT_W'(hbm_pkg::QUO_BITS - 1);
   end

   assign score_q16     = score_ff;
   assign valid_offsets = vo_ff;
   assign status        = status_ff;

endmodule

@@ design/hbm_ctrl.sv @@
// hash bit error rate matcher controller: sequences decode, store walk,
// pipeline drain and division, and strobes the response; depends on hbm_pkg
module hbm_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output hbm_pkg::hbm_cmd_type cmd,
   input  hbm_pkg::hbm_sts_type sts,
   output logic                 rsp_valid
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   // state and response strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (sts.go_scan) begin
                  state_ff <= ST_SCAN;
               end else begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_SCAN: begin
               if (sts.issue_last) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               if (!sts.pipe_busy) begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (sts.div_last) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // commands decoded from state
   always_comb begin
      cmd.latch    = (state_ff == ST_IDLE) && start;
      cmd.exec     = state_ff == ST_EXEC;
      cmd.scan     = state_ff == ST_SCAN;
      cmd.div_init = (state_ff == ST_DRAIN) && !sts.pipe_busy;
      cmd.div_step = state_ff == ST_DIV;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ design/hash_bit_error_rate_matcher.sv @@
// clear and append: response strobe follows the exec state; the block is idle again as it rises
// score: the shorter sequence is walked in whole blocks, one word read per cycle
// from the two store rams, then the error pipeline drains and 17 divider steps run
// failed score checks respond from the exec state; the receiver cannot stall
// synchronous active-high reset clears counts, config to defaults, controller idle
// depends on hbm_pkg, hbm_ctrl, hbm_datapath and hbm_ram
module hash_bit_error_rate_matcher #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [hbm_pkg::FUNC_W-1:0]        req_func,
   input  logic [hbm_pkg::WORD_W-1:0]        req_hash_word,
   input  logic [hbm_pkg::OFF_W-1:0]         req_offset,
   output logic                              rsp_valid,
   output logic [hbm_pkg::SCORE_W-1:0]       rsp_score_q16,
   output logic [hbm_pkg::VO_W-1:0]          rsp_valid_offsets,
   output logic [hbm_pkg::STATUS_W-1:0]      rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [hbm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hbm_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   hbm_pkg::hbm_cmd_type cmd;
   hbm_pkg::hbm_sts_type sts;

   // register writes always taken
   assign csr_ready = 1'b1;

   hbm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid)
   );

   hbm_datapath #(.STORE_DEPTH(STORE_DEPTH)) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .sts           (sts),
      .req_func      (req_func),
      .req_hash_word (req_hash_word),
      .req_offset    (req_offset),
      .csr_wr        (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .score_q16     (rsp_score_q16),
      .valid_offsets (rsp_valid_offsets),
      .status        (rsp_status)
   );

`ifndef NO_ASSERTIONS
   // an accepted transaction holds the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted transaction did not raise busy");

   // one response strobe per transaction, never back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe lasted more than one cycle");

   // failed transactions carry a zero score
   a_fail_zero_score: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != hbm_pkg::STATUS_OK)) |-> (rsp_score_q16 == '0))
      else $error("nonzero score with error status");

   // score never exceeds one in q16
   a_score_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_score_q16 <= 17'd65536))
      else $error("score above full scale");
`endif

endmodule

@@ tb/hash_bit_error_rate_matcher_tb.sv @@
`timescale 1ns / 100ps
// self-checking testbench for hash_bit_error_rate_matcher: a directed stimulus table,
// random store-building and score phases, and a fill-to-capacity phase, checked against
// an in-bench bit error rate predictor or typed-in values; depends on hbm_pkg and the rtl top
module hash_bit_error_rate_matcher_tb;
   import hbm_pkg::*;

   localparam int DEPTH        = 1024;
   localparam int RANDOM_ITEMS = 400;
   localparam int TAIL_CYCLES  = 64;
   localparam int NUM_ROWS     = 33;

   // register index with no register behind it
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [SCORE_W-1:0]  score;
      logic [VO_W-1:0]     valid_offsets;
      logic [STATUS_W-1:0] status;
   } match_result_t;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_e;

   typedef enum int {NOISE_NONE, NOISE_BIT, NOISE_SPARSE, NOISE_FULL} noise_e;

   typedef struct packed {
      row_kind_e            kind;
      logic [CSR_IDX_W-1:0] reg_idx;
      logic [FUNC_W-1:0]    func;
      logic [WORD_W-1:0]    data;
      logic [OFF_W-1:0]     offset;
      logic                 typed;
      match_result_t        result;
   } stim_row_t;

   localparam match_result_t RES_NONE  = '0;
   localparam match_result_t RES_SHORT = '{17'd0, 11'd0, STATUS_SHORT};

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [FUNC_W-1:0]     req_func;
   logic [WORD_W-1:0]     req_hash_word;
   logic [OFF_W-1:0]      req_offset;
   logic                  rsp_valid;
   logic [SCORE_W-1:0]    rsp_score_q16;
   logic [VO_W-1:0]       rsp_valid_offsets;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // predictor state: both stores, their word counts and the two registers
   logic [WORD_W-1:0] store_words [2][DEPTH];
   int unsigned       store_len [2];
   logic [BW_W-1:0]   cfg_block_words;
   logic [THR_W-1:0]  cfg_threshold;

   match_result_t pending_results [$];
   int            mismatch_count;
   int            results_seen;
   int            item_count;
   int            status_seen [4];
   bit            no_gaps;
   bit            drained_once;

   // directed stimulus, expected values typed in only where obvious
   stim_row_t directed_rows [NUM_ROWS] = '{
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd0, 1'b1, RES_SHORT},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_CLEAR, 32'h0000_0000, 10'd0, 1'b1, RES_NONE},
      '{ROW_CSR, CSR_BLOCK_WORDS, FUNC_CLEAR, 32'h0000_0000, 10'd0, 1'b0, RES_NONE},
      '{ROW_CSR, CSR_UNUSED, FUNC_CLEAR, 32'hFFFF_FFFF, 10'd0, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_APPEND1, 32'h0000_0000, 10'd0, 1'b1, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_APPEND2, 32'hFFFF_FFFF, 10'd1023, 1'b1, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd0, 1'b1,
        '{17'd32768, 11'd1, STATUS_OK}},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd1, 1'b1,
        '{17'd0, 11'd1, STATUS_RANGE}},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'hFFFF_FFFF, 10'd1023, 1'b1,
        '{17'd0, 11'd1, STATUS_RANGE}},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_APPEND2, 32'h0000_0000, 10'd0, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_APPEND2, 32'hA5A5_5A5A, 10'd0, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd1, 1'b1,
        '{17'd65536, 11'd3, STATUS_OK}},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd2, 1'b0, RES_NONE},
      '{ROW_CSR, CSR_THRESHOLD, FUNC_CLEAR, 32'h0001_0000, 10'd0, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd2, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd0, 1'b0, RES_NONE},
      '{ROW_CSR, CSR_THRESHOLD, FUNC_CLEAR, 32'h0000_0000, 10'd0, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd1, 1'b0, RES_NONE},
      '{ROW_CSR, CSR_THRESHOLD, FUNC_CLEAR, 32'h0001_FFFF, 10'd0, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd2, 1'b0, RES_NONE},
      '{ROW_CSR, CSR_BLOCK_WORDS, FUNC_CLEAR, 32'h0000_07FF, 10'd0, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd0, 1'b1, RES_SHORT},
      '{ROW_CSR, CSR_BLOCK_WORDS, FUNC_CLEAR, 32'h0000_0002, 10'd0, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_APPEND1, 32'hFFFF_0000, 10'd0, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_APPEND1, 32'h1234_5678, 10'd0, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd0, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_APPEND1, 32'hDEAD_BEEF, 10'd0, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd1, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd2, 1'b1,
        '{17'd0, 11'd2, STATUS_RANGE}},
      '{ROW_CSR, CSR_BLOCK_WORDS, FUNC_CLEAR, 32'h0000_0400, 10'd0, 1'b0, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd0, 1'b1, RES_SHORT},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_CLEAR, 32'h0000_0000, 10'd0, 1'b1, RES_NONE},
      '{ROW_ITEM, CSR_BLOCK_WORDS, FUNC_SCORE, 32'h0000_0000, 10'd0, 1'b1, RES_SHORT}
   };

   hash_bit_error_rate_matcher u_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_hash_word     (req_hash_word),
      .req_offset        (req_offset),
      .rsp_valid         (rsp_valid),
      .rsp_score_q16     (rsp_score_q16),
      .rsp_valid_offsets (rsp_valid_offsets),
      .rsp_status        (rsp_status),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin
      #100_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // predictor: updates the store model and returns the expected response
   function automatic match_result_t predict_match(input logic [FUNC_W-1:0] f,
         input logic [WORD_W-1:0] w, input logic [OFF_W-1:0] off);
      match_result_t   r;
      int unsigned     bw, n_short, n_long, n_pos, blocks, bits, errs, k, j;
      int              s, l;
      longint unsigned agree, disagree, total;
      r = '0;
      case (f)
         FUNC_CLEAR: begin
            store_len[0] = 0;
            store_len[1] = 0;
         end
         FUNC_APPEND1, FUNC_APPEND2: begin
            s = (f == FUNC_APPEND1) ? 0 : 1;
            if (store_len[s] >= DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               store_words[s][store_len[s]] = w;
               store_len[s]++;
            end
         end
         default: begin
            bw = (cfg_block_words == 0) ? 1 : cfg_block_words;
            // equal lengths: the first store plays the shorter sequence
            s = (store_len[0] <= store_len[1]) ? 0 : 1;
            l = 1 - s;
            n_short = store_len[s];
            n_long = store_len[l];
            if (n_short < bw) begin
               r.status = STATUS_SHORT;
            end else begin
               n_pos = n_long - n_short + 1;
               r.valid_offsets = n_pos[VO_W-1:0];
               if (off >= n_pos) begin
                  r.status = STATUS_RANGE;
               end else begin
                  blocks = n_short / bw;
                  bits = 32 * bw;
                  agree = 0;
                  disagree = 0;
                  for (k = 0; k < blocks; k++) begin
                     errs = 0;
                     for (j = 0; j < bw; j++) begin
                        errs += $countones(store_words[s][k * bw + j] ^
                                           store_words[l][off + k * bw + j]);
                     end
                     if (64'(errs) * 65536 <= 64'(cfg_threshold) * bits)
                        agree += bits - errs;
                     else
                        disagree += bits - errs;
                  end
                  total = 64'(blocks) * bits;
                  r.score = SCORE_W'((64'd32768 * (total + agree - disagree)) / total);
               end
            end
         end
      endcase
      return r;
   endfunction

   // flip bits of a word by a chosen amount
   function automatic logic [WORD_W-1:0] disturb(input logic [WORD_W-1:0] w,
         input noise_e level);
      case (level)
         NOISE_NONE:   return w;
         NOISE_BIT:    return w ^ (32'd1 << $urandom_range(0, 31));
         NOISE_SPARSE: return w ^ ($urandom & $urandom & $urandom);
         default:      return w ^ $urandom;
      endcase
   endfunction

   // sender gap: mostly none or short, a few long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 40);
   endfunction

   task automatic pause_cycles(input int n);
      if (n > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // drive one transaction and queue its expected response at acceptance
   task automatic issue_item(input logic [FUNC_W-1:0] f, input logic [WORD_W-1:0] w,
         input logic [OFF_W-1:0] off, input bit typed = 1'b0,
         input match_result_t typed_result = '0);
      match_result_t predicted;
      pause_cycles(pick_gap());
      @(negedge clock);
      start = 1'b1;
      req_func = f;
      req_hash_word = w;
      req_offset = off;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = predict_match(f, w, off);
      pending_results.push_back(typed ? typed_result : predicted);
      item_count++;
   endtask

   // sender pause until every queued response has come back
   task automatic wait_for_drain();
      @(negedge clock);
      start = 1'b0;
      while (pending_results.size() != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
         input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_BLOCK_WORDS)
         cfg_block_words = data[BW_W-1:0];
      else if (idx == CSR_THRESHOLD)
         cfg_threshold = data[THR_W-1:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // idle the block, then write both registers in random order with junk up top
   task automatic set_config(input logic [BW_W-1:0] bw, input logic [THR_W-1:0] thr);
      logic [CSR_DATA_W-1:0] bw_data, thr_data;
      bw_data = {21'($urandom), bw};
      thr_data = {15'($urandom), thr};
      wait_for_drain();
      if ($urandom_range(0, 1)) begin
         write_register(CSR_BLOCK_WORDS, bw_data);
         write_register(CSR_THRESHOLD, thr_data);
      end else begin
         write_register(CSR_THRESHOLD, thr_data);
         write_register(CSR_BLOCK_WORDS, bw_data);
      end
   endtask

   // one random phase: config, build two related sequences, score them
   task automatic run_match_phase();
      int unsigned       sz, eff, n_short, n_long, extra, align, pick, i_s, i_l, n_scores, i;
      int                short_store, noise_max;
      logic [BW_W-1:0]   bw;
      logic [THR_W-1:0]  thr;
      logic [OFF_W-1:0]  off;
      logic [WORD_W-1:0] short_words [$];
      logic [WORD_W-1:0] long_words [$];
      no_gaps = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 19);
      if (pick == 0) bw = '0;
      else if (pick == 1) bw = BW_W'($urandom_range(1025, 2047));
      else if (pick < 5) bw = BW_W'($urandom_range(9, 24));
      else bw = BW_W'($urandom_range(1, 8));
      pick = $urandom_range(0, 9);
      if (pick == 0) thr = '0;
      else if (pick == 1) thr = 17'd65536;
      else if (pick == 2) thr = THR_W'($urandom_range(65537, 131071));
      else thr = THR_W'($urandom_range(4000, 36000));
      set_config(bw, thr);

      eff = (bw == 0) ? 1 : bw;
      sz = (eff > 24) ? $urandom_range(1, 8) : eff;
      n_short = sz * $urandom_range(1, 5) + $urandom_range(0, sz - 1);
      if ($urandom_range(0, 7) == 0) n_short = sz - 1;
      extra = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      n_long = n_short + extra;
      align = $urandom_range(0, extra);
      noise_max = $urandom_range(0, 3);
      short_store = $urandom_range(0, 1);

      // longer sequence carries a disturbed copy of the shorter one at align
      for (i = 0; i < n_short; i++) short_words.push_back($urandom);
      for (i = 0; i < n_long; i++) begin
         if (i >= align && i < align + n_short)
            long_words.push_back(disturb(short_words[i - align],
                                         noise_e'($urandom_range(0, noise_max))));
         else
            long_words.push_back($urandom);
      end

      if ($urandom_range(0, 4) != 0 || store_len[0] > 600 || store_len[1] > 600)
         issue_item(FUNC_CLEAR, $urandom, OFF_W'($urandom));

      // appends interleaved between the stores, with a stray query now and then
      i_s = 0;
      i_l = 0;
      while (i_s < n_short || i_l < n_long) begin
         if (i_l >= n_long || (i_s < n_short && $urandom_range(0, 1))) begin
            issue_item(short_store ? FUNC_APPEND2 : FUNC_APPEND1, short_words[i_s],
                       OFF_W'($urandom));
            i_s++;
         end else begin
            issue_item(short_store ? FUNC_APPEND1 : FUNC_APPEND2, long_words[i_l],
                       OFF_W'($urandom));
            i_l++;
         end
         if ($urandom_range(0, 29) == 0)
            issue_item(FUNC_SCORE, $urandom, OFF_W'($urandom_range(0, 15)));
      end

      if (!drained_once || $urandom_range(0, 2) == 0) begin
         wait_for_drain();
         drained_once = 1'b1;
      end

      n_scores = $urandom_range(2, 6);
      for (i = 0; i < n_scores; i++) begin
         pick = $urandom_range(0, 9);
         if (pick < 5) off = OFF_W'(align);
         else if (pick < 8) off = OFF_W'($urandom_range(0, extra));
         else if (pick == 8) off = OFF_W'($urandom_range(extra + 1, 1023));
         else off = 10'd1023;
         issue_item(FUNC_SCORE, $urandom, off);
      end
   endtask

   // fill both stores to capacity, overflow each, score at the largest sizes
   task automatic run_fill_phase();
      int unsigned i;
      no_gaps = 1'b1;
      set_config(11'd1, THR_RESET);
      issue_item(FUNC_CLEAR, $urandom, OFF_W'($urandom));
      for (i = 0; i < DEPTH; i++) issue_item(FUNC_APPEND1, $urandom, OFF_W'($urandom));
      issue_item(FUNC_APPEND1, $urandom, OFF_W'($urandom));
      issue_item(FUNC_APPEND2, store_words[0][DEPTH - 1], OFF_W'($urandom));
      issue_item(FUNC_SCORE, $urandom, 10'd1023);
      issue_item(FUNC_SCORE, $urandom, 10'd0);
      issue_item(FUNC_SCORE, $urandom, OFF_W'($urandom_range(1, 1022)));

      // second store mirrors the first with noise that grows along the store
      for (i = 1; i < DEPTH; i++)
         issue_item(FUNC_APPEND2, disturb(store_words[0][i], noise_e'(i / 256)),
                    OFF_W'($urandom));
      issue_item(FUNC_APPEND2, $urandom, OFF_W'($urandom));

      set_config(11'd1024, THR_RESET);
      issue_item(FUNC_SCORE, $urandom, 10'd0);
      issue_item(FUNC_SCORE, $urandom, 10'd1);
      set_config(11'd1000, 17'd65536);
      issue_item(FUNC_SCORE, $urandom, 10'd0);
      set_config(11'd0, 17'd0);
      issue_item(FUNC_SCORE, $urandom, 10'd0);
      set_config(11'd7, 17'd131071);
      issue_item(FUNC_SCORE, $urandom, 10'd0);
      set_config(11'd32, THR_W'($urandom_range(4000, 36000)));
      issue_item(FUNC_SCORE, $urandom, 10'd0);
   endtask

   // response checker: every strobe against the oldest expectation
   always @(posedge clock) begin
      match_result_t want;
      if (!reset && rsp_valid) begin
         results_seen++;
         status_seen[rsp_status]++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected response score_q16 %0d valid_offsets %0d status %0d",
                     $time, rsp_score_q16, rsp_valid_offsets, rsp_status);
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_score_q16 !== want.score) begin
               $display("%0t: score_q16 expected %0d actual %0d",
                        $time, want.score, rsp_score_q16);
               mismatch_count++;
            end
            if (rsp_valid_offsets !== want.valid_offsets) begin
               $display("%0t: valid_offsets expected %0d actual %0d",
                        $time, want.valid_offsets, rsp_valid_offsets);
               mismatch_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_status);
               mismatch_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      int directed_items;
      reset = 1'b1;
      start = 1'b0;
      req_func = FUNC_CLEAR;
      req_hash_word = '0;
      req_offset = '0;
      csr_valid = 1'b0;
      csr_index = CSR_BLOCK_WORDS;
      csr_wdata = '0;
      store_len[0] = 0;
      store_len[1] = 0;
      cfg_block_words = BW_RESET;
      cfg_threshold = THR_RESET;
      mismatch_count = 0;
      results_seen = 0;
      item_count = 0;
      status_seen = '{default: 0};
      no_gaps = 1'b0;
      drained_once = 1'b0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (directed_rows[row]) begin
         if (directed_rows[row].kind == ROW_CSR) begin
            wait_for_drain();
            write_register(directed_rows[row].reg_idx, directed_rows[row].data);
         end else begin
            issue_item(directed_rows[row].func, directed_rows[row].data,
                       directed_rows[row].offset, directed_rows[row].typed,
                       directed_rows[row].result);
         end
      end
      directed_items = item_count;

      // random phases, then the capacity phase
      while (item_count < directed_items + RANDOM_ITEMS) run_match_phase();
      run_fill_phase();

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("%0d transactions checked: %0d ok, %0d too short, %0d out of range, %0d full",
               results_seen, status_seen[STATUS_OK], status_seen[STATUS_SHORT],
               status_seen[STATUS_RANGE], status_seen[STATUS_FULL]);
      $display("block sizes 0 to 2047, thresholds 0 to 131071, both stores run to capacity");
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

@@ hash_bit_error_rate_matcher.f @@
design/hbm_pkg.sv
design/hbm_ram.sv
design/hbm_datapath.sv
design/hbm_ctrl.sv
design/hash_bit_error_rate_matcher.sv
tb/hash_bit_error_rate_matcher_tb.sv
